// ===== src/klru_pkg.sv =====
// Package for the kernel log record unescaper: item structs, run entry,
// state codes, character constants and the hex digit decoder. No dependencies.
`default_nettype none
package klru_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_RUN     = 4;

  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_NL    = 8'h0A;  // '\n'
  localparam logic [7:0] CH_BSL   = 8'h5C;  // '\\'
  localparam logic [7:0] CH_X     = 8'h78;  // 'x'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_record;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       record_done;
    logic       record_has_text;
    logic       last_of_run;
  } out_item_t;

  // All results caused by one item, handed from front to back.
  typedef struct packed {
    logic [MAX_RUN-1:0][7:0] bytes;
    logic [2:0]              count;     // results in this run, 1..4
    logic                    bare;      // lone end marker, no byte
    logic                    rec_last;  // item closed the record
    logic                    has_text;  // record emitted text so far
  } run_t;

  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_PREFIX = 5'b00010,
    PH_MSG    = 5'b00100,
    PH_AFTER  = 5'b01000,
    PH_IGNORE = 5'b10000
  } phase_t;

  typedef enum logic [3:0] {
    ESC_NONE = 4'b0001,
    ESC_BSL  = 4'b0010,
    ESC_X    = 4'b0100,
    ESC_HEX  = 4'b1000
  } esc_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/klru_front.sv =====
// Front end: accepts bytes, tracks record phase and escape state, and builds
// one run entry per item that causes results. Depends on klru_pkg.
`default_nettype none
module klru_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire klru_pkg::in_item_t in_data,
  output logic                   push_valid,
  output klru_pkg::run_t         push_data,
  input  wire logic              q_ready
);

  klru_pkg::phase_t phase_r, phase_nxt;
  klru_pkg::esc_t   esc_r, esc_nxt;
  logic [7:0]       held_r, held_nxt;
  logic             te_r, te_nxt;
  klru_pkg::run_t   run;
  logic [4:0]       hc, hh;
  logic             emitted, accept;

  function automatic klru_pkg::run_t push_byte(klru_pkg::run_t r, logic [7:0] b);
    klru_pkg::run_t o;
    o = r;
    o.bytes[r.count[1:0]] = b;
    o.count = r.count + 3'd1;
    return o;
  endfunction

  function automatic klru_pkg::run_t flush_held(klru_pkg::run_t r, klru_pkg::esc_t e,
                                                logic [7:0] h);
    klru_pkg::run_t o;
    o = r;
    if (e != klru_pkg::ESC_NONE) o = push_byte(o, klru_pkg::CH_BSL);
    if (e == klru_pkg::ESC_X || e == klru_pkg::ESC_HEX) o = push_byte(o, klru_pkg::CH_X);
    if (e == klru_pkg::ESC_HEX) o = push_byte(o, h);
    return o;
  endfunction

  assign hc = klru_pkg::hex_decode(in_data.in_byte);
  assign hh = klru_pkg::hex_decode(held_r);

  always_comb begin
    logic [7:0] c;
    logic       do_plain;
    c         = in_data.in_byte;
    do_plain  = 1'b0;
    run       = '0;
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    held_nxt  = held_r;
    case (phase_r)
      klru_pkg::PH_START: begin
        if (c == klru_pkg::CH_SPACE) phase_nxt = klru_pkg::PH_IGNORE;
        else if (c == klru_pkg::CH_SEMI) phase_nxt = klru_pkg::PH_MSG;
        else phase_nxt = klru_pkg::PH_PREFIX;
      end
      klru_pkg::PH_PREFIX: begin
        if (c == klru_pkg::CH_SEMI) phase_nxt = klru_pkg::PH_MSG;
      end
      klru_pkg::PH_MSG: begin
        if (c == klru_pkg::CH_NL) begin
          run       = flush_held(run, esc_r, held_r);
          esc_nxt   = klru_pkg::ESC_NONE;
          held_nxt  = 8'd0;
          phase_nxt = klru_pkg::PH_AFTER;
        end else begin
          case (esc_r)
            klru_pkg::ESC_NONE: do_plain = 1'b1;
            klru_pkg::ESC_BSL: begin
              if (c == klru_pkg::CH_X) begin
                esc_nxt = klru_pkg::ESC_X;
              end else begin
                esc_nxt  = klru_pkg::ESC_NONE;
                run      = push_byte(run, klru_pkg::CH_BSL);
                do_plain = 1'b1;
              end
            end
            klru_pkg::ESC_X: begin
              if (hc[4]) begin
                held_nxt = c;
                esc_nxt  = klru_pkg::ESC_HEX;
              end else begin
                esc_nxt  = klru_pkg::ESC_NONE;
                run      = push_byte(run, klru_pkg::CH_BSL);
                run      = push_byte(run, klru_pkg::CH_X);
                do_plain = 1'b1;
              end
            end
            klru_pkg::ESC_HEX: begin
              esc_nxt  = klru_pkg::ESC_NONE;
              held_nxt = 8'd0;
              if (hc[4]) begin
                run = push_byte(run, {hh[3:0], hc[3:0]});
              end else begin
                run      = push_byte(run, klru_pkg::CH_BSL);
                run      = push_byte(run, klru_pkg::CH_X);
                run      = push_byte(run, held_r);
                do_plain = 1'b1;
              end
            end
            default: esc_nxt = klru_pkg::ESC_NONE;
          endcase
          if (do_plain) begin
            if (c == klru_pkg::CH_BSL) esc_nxt = klru_pkg::ESC_BSL;
            else run = push_byte(run, c);
          end
        end
      end
      default: ;
    endcase

    // end of record inside the message: flush what is still held
    if (in_data.end_of_record && phase_nxt == klru_pkg::PH_MSG) begin
      run      = flush_held(run, esc_nxt, held_nxt);
      esc_nxt  = klru_pkg::ESC_NONE;
      held_nxt = 8'd0;
    end

    emitted = (run.count != 3'd0);
    te_nxt  = te_r | emitted;
    run.bare     = in_data.end_of_record && !emitted;
    run.rec_last = in_data.end_of_record;
    run.has_text = te_nxt;
    if (run.bare) run.count = 3'd1;
  end

  assign in_ready   = q_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = accept && (emitted || in_data.end_of_record);
  assign push_data  = run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= klru_pkg::PH_START;
      esc_r   <= klru_pkg::ESC_NONE;
      held_r  <= 8'd0;
      te_r    <= 1'b0;
    end else if (accept) begin
      if (in_data.end_of_record) begin
        phase_r <= klru_pkg::PH_START;
        esc_r   <= klru_pkg::ESC_NONE;
        held_r  <= 8'd0;
        te_r    <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        esc_r   <= esc_nxt;
        held_r  <= held_nxt;
        te_r    <= te_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/klru_queue.sv =====
// Short run queue between front and back ends.
// Depends on klru_pkg for the run entry type.
`default_nettype none
module klru_queue #(
  parameter int DEPTH = klru_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  input  wire klru_pkg::run_t push_data,
  output logic                q_ready,
  output logic                head_valid,
  output klru_pkg::run_t      head_data,
  input  wire logic           pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  klru_pkg::run_t slots_r [DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign q_ready    = (cnt_r != CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = slots_r[rd_r];
  assign do_push    = push_valid && q_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    if (do_pop)  rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/klru_back.sv =====
// Back end: walks the head run entry and hands out one result per cycle while out_ready is high.
// Depends on klru_pkg.
`default_nettype none
module klru_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            head_valid,
  input  wire klru_pkg::run_t  head_data,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output klru_pkg::out_item_t  out_data
);

  logic [1:0] k_r, k_nxt;
  logic [2:0] last_idx;
  logic       fin, take;

  assign last_idx  = head_data.count - 3'd1;
  assign fin       = ({1'b0, k_r} == last_idx);
  assign out_valid = head_valid;
  assign take      = out_valid && out_ready;
  assign pop       = take && fin;

  always_comb begin
    out_data.out_byte        = head_data.bare ? 8'd0 : head_data.bytes[k_r];
    out_data.byte_valid      = !head_data.bare;
    out_data.record_done     = head_data.rec_last && fin;
    out_data.record_has_text = head_data.rec_last && fin && head_data.has_text;
    out_data.last_of_run     = fin;
    k_nxt = k_r;
    if (take) k_nxt = fin ? 2'd0 : k_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) k_r <= 2'd0;
    else        k_r <= k_nxt;
  end

endmodule
`default_nettype wire

// ===== src/kernel_log_record_unescaper.sv =====
// Kernel log record unescaper, top level. Results are registered in the queue
// before reaching the output. Throughput: 1 item per cycle while the queue has
// room; an item that causes n results (n up to 4) has them walked out by the
// back end one result a cycle while out_ready is high. Synchronous active-low
// reset clears record state and empties the queue; no clearing pass.
// Depends on klru_pkg, klru_front, klru_queue, klru_back.
`default_nettype none
module kernel_log_record_unescaper #(
  parameter int QUEUE_DEPTH = klru_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input channel: one raw record byte per item
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire klru_pkg::in_item_t  in_data,
  // result channel: one decoded byte or end marker per item
  output logic                     out_valid,
  input  wire logic                out_ready,
  output klru_pkg::out_item_t      out_data
);

  // Front end classifies each byte and packs all results it causes into one
  // run entry; items that produce nothing never reach the queue.
  logic           push_valid, q_ready;
  klru_pkg::run_t push_data;

  // Head of the queue, seen by the back end.
  logic           head_valid, pop;
  klru_pkg::run_t head_data;

  klru_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_data  (push_data),
    .q_ready    (q_ready)
  );

  // Queue decouples the two sides: while it has room, the front keeps taking
  // bytes as the back is still draining a multi-byte escape flush.
  klru_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .q_ready    (q_ready),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  // Back end emits the run one result at a time; the final one carries
  // last_of_run and, at record end, the completion flags.
  klru_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire
